// ----- sv/svie_pkg.sv -----
// Package for the stack VM instruction executor.
// Holds the opcodes, status codes, sequencer states and reset constants.
// No dependencies.
package svie_pkg;

  localparam int unsigned DATA_WORDS_DEF    = 4096;
  localparam int unsigned PROGRAM_WORDS_DEF = 65536;

  localparam logic [15:0] STACK_TOP_RST = 16'd32768;
  localparam logic [15:0] ENTRY_RST     = 16'd0;

  // opcodes
  localparam logic [5:0] OP_IMM    = 6'd0;
  localparam logic [5:0] OP_LOADC  = 6'd1;
  localparam logic [5:0] OP_LOADI  = 6'd2;
  localparam logic [5:0] OP_STOREC = 6'd3;
  localparam logic [5:0] OP_STOREI = 6'd4;
  localparam logic [5:0] OP_PUSH   = 6'd5;
  localparam logic [5:0] OP_JMP    = 6'd6;
  localparam logic [5:0] OP_JZ     = 6'd7;
  localparam logic [5:0] OP_JNZ    = 6'd8;
  localparam logic [5:0] OP_CALL   = 6'd9;
  localparam logic [5:0] OP_RET    = 6'd10;
  localparam logic [5:0] OP_ENT    = 6'd11;
  localparam logic [5:0] OP_ADJ    = 6'd12;
  localparam logic [5:0] OP_LEV    = 6'd13;
  localparam logic [5:0] OP_LEA    = 6'd14;
  localparam logic [5:0] OP_OR     = 6'd15;
  localparam logic [5:0] OP_XOR    = 6'd16;
  localparam logic [5:0] OP_AND    = 6'd17;
  localparam logic [5:0] OP_EQ     = 6'd18;
  localparam logic [5:0] OP_NE     = 6'd19;
  localparam logic [5:0] OP_LT     = 6'd20;
  localparam logic [5:0] OP_LE     = 6'd21;
  localparam logic [5:0] OP_GT     = 6'd22;
  localparam logic [5:0] OP_GE     = 6'd23;
  localparam logic [5:0] OP_SHL    = 6'd24;
  localparam logic [5:0] OP_SHR    = 6'd25;
  localparam logic [5:0] OP_ADD    = 6'd26;
  localparam logic [5:0] OP_SUB    = 6'd27;
  localparam logic [5:0] OP_MUL    = 6'd28;
  localparam logic [5:0] OP_DIV    = 6'd29;
  localparam logic [5:0] OP_MOD    = 6'd30;
  localparam logic [5:0] OP_EXIT   = 6'd31;
  localparam logic [5:0] OP_HOST_LO = 6'd32;
  localparam logic [5:0] OP_HOST_HI = 6'd38;

  // status codes
  localparam logic [2:0] STS_OK     = 3'd0;
  localparam logic [2:0] STS_EXIT   = 3'd1;
  localparam logic [2:0] STS_BADOP  = 3'd2;
  localparam logic [2:0] STS_DIV0   = 3'd3;
  localparam logic [2:0] STS_BADADR = 3'd4;
  localparam logic [2:0] STS_HOST   = 3'd5;

  // register indexes
  localparam logic CFG_STACK_TOP = 1'b0;
  localparam logic CFG_ENTRY     = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_MUL,
    S_DIV,
    S_DONE
  } seq_state_t;

endpackage

// ----- sv/stack_vm_instruction_executor.sv -----
// Stack VM instruction executor: sequencer, data memory, multiply and divide units.
// Depends on svie_pkg.
//
// One word in gives one word out. A simple instruction is accepted, then
// committed with the data-memory read that was issued at accept. STOREC and
// LEV need a second read of the single-port data memory; MUL forms three 32x32
// partial products on one multiplier; DIV and MOD use a radix-2 divider, one
// quotient bit per cycle. Once halted every word goes from accept straight to
// commit and repeats the halting result. The input is taken whenever the
// sequencer is idle, also while a finished result still waits in the output
// register; a result only stalls the commit of the next one. Configuration
// writes load the pointers or the program counter directly and are meant for
// idle periods only. Data memory contents are undefined after reset.
module stack_vm_instruction_executor
  import svie_pkg::*;
#(
  parameter int unsigned DATA_WORDS    = svie_pkg::DATA_WORDS_DEF,
  parameter int unsigned PROGRAM_WORDS = svie_pkg::PROGRAM_WORDS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // command[5:0], operand[69:6], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata,  // next_address[15:0], accumulator_value[79:16],
                                   // status[82:80], exit_value[146:83], zero pad
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  localparam int unsigned AW = $clog2(DATA_WORDS);
  localparam logic [32:0] PW_RECIP =
    33'(((64'd1 << 32) + 64'(PROGRAM_WORDS) - 64'd1) / 64'(PROGRAM_WORDS));
  localparam logic [16:0] PW17 = 17'(PROGRAM_WORDS);

  // modulo PROGRAM_WORDS by reciprocal multiply and one correction
  function automatic logic [15:0] pmod(input logic [15:0] v);
    logic [48:0] p;
    logic [16:0] q;
    logic [33:0] qp;
    logic [16:0] t;
    p  = 49'(v) * 49'(PW_RECIP);
    q  = p[48:32];
    qp = 34'(q) * 34'(PW17);
    t  = 17'(v) - qp[16:0];
    if (t >= PW17) t = t - PW17;
    return t[15:0];
  endfunction

  function automatic logic addr_ok(input logic [63:0] a);
    return a[63:3] < 61'(DATA_WORDS);
  endfunction

  function automatic logic [AW-1:0] widx(input logic [63:0] a);
    return a[3 +: AW];
  endfunction

  function automatic logic [63:0] umag(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] sext8(input logic [7:0] v);
    return {{56{v[7]}}, v};
  endfunction

  function automatic logic needs_rd1(input logic [5:0] op);
    return (op == OP_STOREC) || (op == OP_LEV) || (op == OP_MUL) ||
           (op == OP_DIV) || (op == OP_MOD);
  endfunction

  // ---------------------------------------------------------------- state
  seq_state_t  state_r, state_nxt;
  logic [15:0] pc_r, sp_r, bp_r;
  logic [63:0] ax_r;
  logic        halted_r;
  logic [2:0]  halt_st_r;
  logic [63:0] halt_xv_r;
  logic [5:0]  op_r;
  logic [63:0] arg_r;
  logic [63:0] a_r;
  logic [63:0] res_r;
  logic [63:0] dq_r, rem_r;
  logic [5:0]  cnt_r;
  logic        out_valid_r;
  logic [151:0] out_data_r;

  logic [63:0] mem [DATA_WORDS];
  logic [63:0] mem_q;
  logic        rd_en;
  logic [AW-1:0] rd_idx;

  logic        in_fire, out_free, commit;
  logic [5:0]  in_cmd;

  assign in_cmd    = in_tdata[5:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign commit    = (state_r == S_DONE) && out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!halted_r && needs_rd1(in_cmd)) state_nxt = S_RD1;
          else state_nxt = S_DONE;
        end
      end
      S_RD1: begin
        if (op_r == OP_MUL) state_nxt = S_MUL;
        else if ((op_r == OP_DIV || op_r == OP_MOD) && ax_r != 64'd0) state_nxt = S_DIV;
        else state_nxt = S_DONE;
      end
      S_MUL:  if (cnt_r == 6'd2) state_nxt = S_DONE;
      S_DIV:  if (cnt_r == 6'd63) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ------------------------------------------------------ memory reads
  logic [15:0] bp8;
  assign bp8 = bp_r + 16'd8;

  always_comb begin
    rd_en  = 1'b0;
    rd_idx = widx({48'd0, sp_r});
    case (state_r)
      S_IDLE: begin
        rd_en = in_fire;
        if (in_cmd == OP_LOADC || in_cmd == OP_LOADI) rd_idx = widx(ax_r);
        else if (in_cmd == OP_LEV) rd_idx = widx({48'd0, bp_r});
        else rd_idx = widx({48'd0, sp_r});
      end
      S_RD1: begin
        if (op_r == OP_STOREC) begin
          rd_en  = 1'b1;
          rd_idx = widx(mem_q);
        end else if (op_r == OP_LEV) begin
          rd_en  = 1'b1;
          rd_idx = widx({48'd0, bp8});
        end
      end
      default: rd_en = 1'b0;
    endcase
  end

  // ------------------------------------------------ execute and commit
  logic [63:0] fw;        // first word read (top of stack, load word, bp word)
  logic [63:0] d_ax, d_xv, d_wdata;
  logic [15:0] d_pc, d_sp, d_bp, pc1, pc2, dec, inc, tgt_pc;
  logic [16:0] pc1_s, pc2_s;
  logic [2:0]  d_st;
  logic        d_we;
  logic [AW-1:0] d_widx;
  logic [5:0]  sh;
  logic [5:0]  lane;
  logic [63:0] byte_mask;

  assign fw  = needs_rd1(op_r) ? a_r : mem_q;
  assign dec = sp_r - 16'd8;
  assign inc = sp_r + 16'd8;
  assign sh  = ax_r[5:0];

  always_comb begin
    pc1_s = 17'(pc_r) + 17'd1;
    if (pc1_s >= PW17) pc1_s = pc1_s - PW17;
    pc2_s = 17'(pc_r) + 17'd2;
    if (pc2_s >= PW17) pc2_s = pc2_s - PW17;
  end
  assign pc1 = pc1_s[15:0];
  assign pc2 = pc2_s[15:0];

  // return address comes from memory for RET and LEV
  always_comb begin
    if (op_r == OP_RET) tgt_pc = pmod(fw[15:0]);
    else if (op_r == OP_LEV) tgt_pc = pmod(mem_q[15:0]);
    else tgt_pc = pmod(arg_r[15:0]);
  end

  always_comb begin
    d_ax    = ax_r;
    d_pc    = pc_r;
    d_sp    = sp_r;
    d_bp    = bp_r;
    d_st    = STS_OK;
    d_xv    = 64'd0;
    d_we    = 1'b0;
    d_widx  = widx({48'd0, dec});
    d_wdata = ax_r;
    lane    = 6'd0;
    byte_mask = 64'd0;
    case (op_r)
      OP_IMM: begin
        d_ax = arg_r;
        d_pc = pc2;
      end
      OP_LOADC: begin
        lane = {ax_r[2:0], 3'b000};
        if (!addr_ok(ax_r)) d_st = STS_BADADR;
        else begin
          d_ax = sext8(8'(fw >> lane));
          d_pc = pc1;
        end
      end
      OP_LOADI: begin
        if (!addr_ok(ax_r)) d_st = STS_BADADR;
        else begin
          d_ax = fw;
          d_pc = pc1;
        end
      end
      OP_STOREC, OP_STOREI: begin
        lane = {fw[2:0], 3'b000};
        byte_mask = 64'hFF << lane;
        if (!addr_ok({48'd0, sp_r}) || !addr_ok(fw)) d_st = STS_BADADR;
        else begin
          d_we   = 1'b1;
          d_widx = widx(fw);
          if (op_r == OP_STOREC) begin
            // merge the byte into the old word from the second read
            d_wdata = (mem_q & ~byte_mask) | ({56'd0, ax_r[7:0]} << lane);
            d_ax    = sext8(ax_r[7:0]);
          end else begin
            d_wdata = ax_r;
          end
          d_sp = inc;
          d_pc = pc1;
        end
      end
      OP_PUSH: begin
        if (!addr_ok({48'd0, dec})) d_st = STS_BADADR;
        else begin
          d_we = 1'b1;
          d_sp = dec;
          d_pc = pc1;
        end
      end
      OP_JMP: d_pc = tgt_pc;
      OP_JZ:  d_pc = (ax_r != 64'd0) ? pc2 : tgt_pc;
      OP_JNZ: d_pc = (ax_r != 64'd0) ? tgt_pc : pc2;
      OP_CALL: begin
        if (!addr_ok({48'd0, dec})) d_st = STS_BADADR;
        else begin
          d_we    = 1'b1;
          d_wdata = {48'd0, pc2};
          d_sp    = dec;
          d_pc    = tgt_pc;
        end
      end
      OP_RET: begin
        if (!addr_ok({48'd0, sp_r})) d_st = STS_BADADR;
        else begin
          d_pc = tgt_pc;
          d_sp = inc;
        end
      end
      OP_ENT: begin
        if (!addr_ok({48'd0, dec})) d_st = STS_BADADR;
        else begin
          d_we    = 1'b1;
          d_wdata = {48'd0, bp_r};
          d_bp    = dec;
          d_sp    = dec - {arg_r[12:0], 3'b000};
          d_pc    = pc2;
        end
      end
      OP_ADJ: begin
        d_sp = sp_r + {arg_r[12:0], 3'b000};
        d_pc = pc2;
      end
      OP_LEV: begin
        if (!addr_ok({48'd0, bp_r}) || !addr_ok({48'd0, bp8})) d_st = STS_BADADR;
        else begin
          d_pc = tgt_pc;
          d_sp = bp_r + 16'd16;
          d_bp = fw[15:0];
        end
      end
      OP_LEA: begin
        d_ax = {48'd0, bp_r} + {arg_r[60:0], 3'b000};
        d_pc = pc2;
      end
      OP_EXIT: begin
        if (!addr_ok({48'd0, sp_r})) d_st = STS_BADADR;
        else begin
          d_xv = fw;
          d_st = STS_EXIT;
          d_pc = pc1;
        end
      end
      default: begin
        if (op_r inside {[OP_OR:OP_MOD]}) begin
          if (!addr_ok({48'd0, sp_r})) d_st = STS_BADADR;
          else if ((op_r == OP_DIV || op_r == OP_MOD) && ax_r == 64'd0) d_st = STS_DIV0;
          else begin
            case (op_r)
              OP_OR:  d_ax = fw | ax_r;
              OP_XOR: d_ax = fw ^ ax_r;
              OP_AND: d_ax = fw & ax_r;
              OP_EQ:  d_ax = {63'd0, fw == ax_r};
              OP_NE:  d_ax = {63'd0, fw != ax_r};
              OP_LT:  d_ax = {63'd0, $signed(fw) <  $signed(ax_r)};
              OP_LE:  d_ax = {63'd0, $signed(fw) <= $signed(ax_r)};
              OP_GT:  d_ax = {63'd0, $signed(fw) >  $signed(ax_r)};
              OP_GE:  d_ax = {63'd0, $signed(fw) >= $signed(ax_r)};
              OP_SHL: d_ax = fw << sh;
              OP_SHR: d_ax = 64'($signed(fw) >>> sh);
              OP_ADD: d_ax = fw + ax_r;
              OP_SUB: d_ax = fw - ax_r;
              OP_MUL: d_ax = res_r;
              OP_DIV: d_ax = (fw[63] ^ ax_r[63]) ? (~dq_r + 64'd1) : dq_r;
              default: d_ax = fw[63] ? (~rem_r + 64'd1) : rem_r;
            endcase
            d_sp = inc;
            d_pc = pc1;
          end
        end else if (op_r >= OP_HOST_LO && op_r <= OP_HOST_HI) begin
          d_st = STS_HOST;
        end else begin
          d_st = STS_BADOP;
        end
      end
    endcase
  end

  logic        d_good;
  logic [15:0] o_pc;
  logic [63:0] o_ax, o_xv;
  logic [2:0]  o_st;
  assign d_good = (d_st == STS_OK) || (d_st == STS_EXIT);

  always_comb begin
    if (halted_r) begin
      o_pc = pc_r;
      o_ax = ax_r;
      o_st = halt_st_r;
      o_xv = halt_xv_r;
    end else begin
      o_pc = d_good ? d_pc : pc_r;
      o_ax = d_good ? d_ax : ax_r;
      o_st = d_st;
      o_xv = d_xv;
    end
  end

  // ------------------------------------------------------- multiplier
  logic [31:0] m_a, m_b;
  logic [63:0] m_p;
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    begin m_a = a_r[31:0];  m_b = ax_r[31:0];  end
      2'd1:    begin m_a = a_r[31:0];  m_b = ax_r[63:32]; end
      default: begin m_a = a_r[63:32]; m_b = ax_r[31:0];  end
    endcase
  end
  assign m_p = 64'(m_a) * 64'(m_b);

  // ---------------------------------------------------------- divider
  logic [64:0] dv_sh;
  logic [63:0] dv_b;
  logic        dv_ge;
  assign dv_b  = umag(ax_r);
  assign dv_sh = {rem_r, dq_r[63]};
  assign dv_ge = dv_sh >= {1'b0, dv_b};

  // ------------------------------------------------------ registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= pmod(ENTRY_RST);
      sp_r        <= STACK_TOP_RST;
      bp_r        <= STACK_TOP_RST;
      ax_r        <= 64'd0;
      halted_r    <= 1'b0;
      halt_st_r   <= STS_OK;
      halt_xv_r   <= 64'd0;
      cnt_r       <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_tready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_addr == CFG_STACK_TOP) begin
          sp_r <= cfg_wdata;
          bp_r <= cfg_wdata;
        end else begin
          pc_r <= pmod(cfg_wdata);
        end
      end
      if (state_r == S_RD1) cnt_r <= 6'd0;
      else if (state_r == S_MUL || state_r == S_DIV) cnt_r <= cnt_r + 6'd1;
      if (commit) begin
        out_valid_r <= 1'b1;
        if (!halted_r) begin
          if (d_good) begin
            pc_r <= d_pc;
            sp_r <= d_sp;
            bp_r <= d_bp;
            ax_r <= d_ax;
          end
          if (d_st != STS_OK) begin
            halted_r  <= 1'b1;
            halt_st_r <= d_st;
            halt_xv_r <= d_xv;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_cmd;
      arg_r <= in_tdata[69:6];
    end
    if (state_r == S_RD1) begin
      a_r   <= mem_q;
      dq_r  <= umag(mem_q);
      rem_r <= 64'd0;
    end
    if (state_r == S_MUL) begin
      if (cnt_r == 6'd0) res_r <= m_p;
      else res_r <= res_r + {m_p[31:0], 32'd0};
    end
    if (state_r == S_DIV) begin
      rem_r <= dv_ge ? 64'(dv_sh - {1'b0, dv_b}) : dv_sh[63:0];
      dq_r  <= {dq_r[62:0], dv_ge};
    end
    if (commit) out_data_r <= {5'd0, o_xv, o_st, o_ax, o_pc};
  end

  // data memory
  always_ff @(posedge clk) begin
    if (commit && !halted_r && d_good && d_we) mem[d_widx] <= d_wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) mem_q <= mem[rd_idx];
  end

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for stack_vm_instruction_executor.
// Depends on svie_pkg and the executor RTL; holds its own instruction predictor.
// Prediction is done before each word is sent; a small scoreboard matches each output word in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import svie_pkg::*;

  // one result word as the block reports it
  typedef struct packed {
    logic [15:0] pc;
    logic [63:0] acc;
    logic [2:0]  st;
    logic [63:0] xv;
  } vm_result_t;

  // ordered store of expected results, one per accepted instruction
  class vm_scoreboard;
    vm_result_t pending[$];
    int errors;

    function void note_input(vm_result_t r);
      pending.push_back(r);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
      errors++;
    endtask

    task check(vm_result_t got);
      vm_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", got.acc, 64'd0);
      end else begin
        want = pending.pop_front();
        if (got.pc !== want.pc) report_mismatch("next_address", 64'(got.pc), 64'(want.pc));
        if (got.acc !== want.acc) report_mismatch("accumulator", got.acc, want.acc);
        if (got.st !== want.st) report_mismatch("status", 64'(got.st), 64'(want.st));
        if (got.xv !== want.xv) report_mismatch("exit_value", got.xv, want.xv);
      end
    endtask
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [71:0]  in_tdata;   // command[5:0], operand[69:6], zero pad
  logic         out_tvalid;
  logic         out_tready;
  logic [151:0] out_tdata;  // next_address[15:0], accumulator_value[79:16],
                            // status[82:80], exit_value[146:83], zero pad
  logic         cfg_we;
  logic         cfg_addr;
  logic [15:0]  cfg_wdata;

  stack_vm_instruction_executor u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  vm_scoreboard sb = new();

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the machine
  // ---------------------------------------------------------------------------
  logic [15:0] vm_pc, vm_sp, vm_bp;
  logic [63:0] vm_acc;
  bit          vm_halted;
  logic [2:0]  halt_st;
  logic [63:0] halt_xv;
  logic [63:0] data_mem [int];   // only words written since reset exist

  int  items_sent;
  int  words_seen;
  bit  calm_in, calm_out;        // stretches with no idling on either side

  function automatic bit in_range(logic [63:0] a);
    return (a >> 3) < 64'(DATA_WORDS_DEF);
  endfunction

  // fetch a data word; returns 0 when that word was never written
  function automatic bit peek(logic [63:0] a, output logic [63:0] v);
    v = 64'd0;
    if (!data_mem.exists(int'(a >> 3))) return 1'b0;
    v = data_mem[int'(a >> 3)];
    return 1'b1;
  endfunction

  function automatic logic [63:0] sext8(logic [63:0] v);
    return {{56{v[7]}}, v[7:0]};
  endfunction

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // Work out one instruction. Returns 0 if it would read an unwritten word
  // (or merge a byte into one). State changes only when commit is set.
  function automatic bit execute(logic [5:0] op, logic [63:0] arg, bit commit,
                                 output vm_result_t r);
    logic [15:0] pc, sp, bp, pc1, pc2, dec, inc, b1;
    logic [63:0] ax, a, b, q, xv, wa, wv;
    logic [2:0]  st;
    logic [5:0]  sh;
    bit          wr, wbyte, clean;
    clean = 1'b1;
    if (vm_halted) begin
      r = '{pc: vm_pc, acc: vm_acc, st: halt_st, xv: halt_xv};
      return 1'b1;
    end
    pc = vm_pc; sp = vm_sp; bp = vm_bp; ax = vm_acc;
    st = STS_OK; xv = '0; wr = 0; wbyte = 0; wa = '0; wv = '0;
    pc1 = pc + 16'd1; pc2 = pc + 16'd2;
    dec = sp - 16'd8; inc = sp + 16'd8;
    case (op)
      OP_IMM: begin ax = arg; pc = pc2; end
      OP_LOADC, OP_LOADI: begin
        if (!in_range(ax)) st = STS_BADADR;
        else begin
          clean &= peek(ax, a);
          ax = (op == OP_LOADC) ? sext8(a >> {ax[2:0], 3'b000}) : a;
          pc = pc1;
        end
      end
      OP_STOREC, OP_STOREI: begin
        if (!in_range(64'(sp))) st = STS_BADADR;
        else begin
          clean &= peek(64'(sp), a);
          if (!in_range(a)) st = STS_BADADR;
          else begin
            wr = 1; wa = a; wv = ax; wbyte = (op == OP_STOREC);
            if (wbyte) begin
              // a byte merged into an unknown word would leave the rest undefined
              clean &= data_mem.exists(int'(a >> 3));
              ax = sext8(ax);
            end
            sp = inc; pc = pc1;
          end
        end
      end
      OP_PUSH: begin
        if (!in_range(64'(dec))) st = STS_BADADR;
        else begin wr = 1; wa = 64'(dec); wv = ax; sp = dec; pc = pc1; end
      end
      OP_JMP: pc = arg[15:0];
      OP_JZ:  pc = (ax != 0) ? pc2 : arg[15:0];
      OP_JNZ: pc = (ax != 0) ? arg[15:0] : pc2;
      OP_CALL: begin
        if (!in_range(64'(dec))) st = STS_BADADR;
        else begin wr = 1; wa = 64'(dec); wv = 64'(pc2); sp = dec; pc = arg[15:0]; end
      end
      OP_RET: begin
        if (!in_range(64'(sp))) st = STS_BADADR;
        else begin clean &= peek(64'(sp), a); pc = a[15:0]; sp = inc; end
      end
      OP_ENT: begin
        if (!in_range(64'(dec))) st = STS_BADADR;
        else begin
          wr = 1; wa = 64'(dec); wv = 64'(bp); bp = dec;
          sp = dec - 16'(arg * 64'd8); pc = pc2;
        end
      end
      OP_ADJ: begin sp = sp + 16'(arg * 64'd8); pc = pc2; end
      OP_LEV: begin
        b1 = bp + 16'd8;
        if (!in_range(64'(bp)) || !in_range(64'(b1))) st = STS_BADADR;
        else begin
          clean &= peek(64'(bp), a);
          clean &= peek(64'(b1), b);
          pc = b[15:0]; sp = bp + 16'd16; bp = a[15:0];
        end
      end
      OP_LEA: begin ax = 64'(bp) + arg * 64'd8; pc = pc2; end
      OP_EXIT: begin
        if (!in_range(64'(sp))) st = STS_BADADR;
        else begin clean &= peek(64'(sp), xv); st = STS_EXIT; pc = pc1; end
      end
      default: begin
        if (op >= OP_OR && op <= OP_MOD) begin
          if (!in_range(64'(sp))) st = STS_BADADR;
          else begin
            clean &= peek(64'(sp), a);
            b = ax; sh = b[5:0];
            if ((op == OP_DIV || op == OP_MOD) && b == 0) st = STS_DIV0;
            else begin
              case (op)
                OP_OR:  ax = a | b;
                OP_XOR: ax = a ^ b;
                OP_AND: ax = a & b;
                OP_EQ:  ax = 64'(a == b);
                OP_NE:  ax = 64'(a != b);
                OP_LT:  ax = 64'($signed(a) < $signed(b));
                OP_LE:  ax = 64'($signed(a) <= $signed(b));
                OP_GT:  ax = 64'($signed(a) > $signed(b));
                OP_GE:  ax = 64'($signed(a) >= $signed(b));
                OP_SHL: ax = a << sh;
                OP_SHR: ax = $signed(a) >>> sh;
                OP_ADD: ax = a + b;
                OP_SUB: ax = a - b;
                OP_MUL: ax = a * b;
                OP_DIV: begin
                  q = mag(a) / mag(b);
                  ax = (a[63] ^ b[63]) ? -q : q;
                end
                default: begin
                  q = mag(a) % mag(b);
                  ax = a[63] ? -q : q;
                end
              endcase
              sp = inc; pc = pc1;
            end
          end
        end else if (op >= OP_HOST_LO && op <= OP_HOST_HI) st = STS_HOST;
        else st = STS_BADOP;
      end
    endcase

    // faults leave every register as it was
    if (st >= STS_BADOP) r = '{pc: vm_pc, acc: vm_acc, st: st, xv: '0};
    else r = '{pc: pc, acc: ax, st: st, xv: (st == STS_EXIT) ? xv : 64'd0};

    if (commit) begin
      if (st >= STS_BADOP) begin
        vm_halted = 1; halt_st = st; halt_xv = '0;
      end else begin
        if (wr) begin
          if (wbyte) begin
            if (!data_mem.exists(int'(wa >> 3))) data_mem[int'(wa >> 3)] = '0;
            data_mem[int'(wa >> 3)][{wa[2:0], 3'b000} +: 8] = wv[7:0];
          end else data_mem[int'(wa >> 3)] = wv;
        end
        vm_pc = pc; vm_sp = sp; vm_bp = bp; vm_acc = ax;
        if (st == STS_EXIT) begin vm_halted = 1; halt_st = STS_EXIT; halt_xv = xv; end
      end
    end
    return clean;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("stack_vm_instruction_executor regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // operands biased towards the interesting corners
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return 64'(int'($urandom_range(0, 16)) - 8);
      3: return 64'($urandom_range(0, 63));
      default: return rand64();
    endcase
  endfunction

  // a byte address inside data memory
  function automatic logic [63:0] data_addr();
    return 64'($urandom_range(0, DATA_WORDS_DEF * 8 - 1));
  endfunction

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic put_word(logic [5:0] op, logic [63:0] arg);
    int gap;
    if (items_sent % 40 == 0) calm_in = ($urandom_range(0, 3) == 0);
    gap = draw_gap(calm_in);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, arg, op};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Predict, then send. Instructions that would halt (unless asked for) or
  // touch unwritten memory are swapped for a plain immediate load.
  task automatic issue(logic [5:0] op, logic [63:0] arg = 64'd0, bit allow_halt = 0);
    vm_result_t r;
    bit ok;
    ok = execute(op, arg, 1'b0, r);
    if (!ok || (!allow_halt && r.st != STS_OK)) begin
      op = OP_IMM;
      arg = pick_operand();
    end
    ok = execute(op, arg, 1'b1, r);
    sb.note_input(r);
    put_word(op, arg);
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // registers only change while the block is quiet: DIV/MOD may still be busy
  task automatic program_regs(logic [15:0] top, logic [15:0] entry);
    idle_input();
    wait_drained();
    repeat (80) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_STACK_TOP;
    cfg_wdata <= top;
    @(posedge clk);
    cfg_addr  <= CFG_ENTRY;
    cfg_wdata <= entry;
    @(posedge clk);
    cfg_we    <= 1'b0;
    vm_sp = top; vm_bp = top; vm_pc = entry;
  endtask

  task automatic store_word(logic [63:0] addr, logic [63:0] val);
    issue(OP_IMM, addr);
    issue(OP_PUSH);
    issue(OP_IMM, val);
    issue(OP_STOREI);
  endtask

  // well-formed fragments with random content, plus some noise
  task automatic random_recipe();
    logic [63:0] addr, r;
    int k;
    case ($urandom_range(0, 9))
      0: issue(6'($urandom_range(0, 31)), pick_operand());
      1, 2: begin
        issue(OP_IMM, pick_operand());
        issue(OP_PUSH);
        issue(OP_IMM, pick_operand());
        issue(6'($urandom_range(OP_OR, OP_MOD)));
      end
      3: begin
        addr = data_addr();
        store_word(addr, rand64());
        if ($urandom_range(0, 1)) begin
          issue(OP_IMM, addr);
          issue(OP_PUSH);
          issue(OP_IMM, pick_operand());
          issue(OP_STOREC);
        end
      end
      4: begin
        addr = data_addr();
        store_word(addr, rand64());
        issue(OP_IMM, {addr[63:3], 3'($urandom_range(0, 7))});
        issue($urandom_range(0, 1) ? OP_LOADC : OP_LOADI);
      end
      5: begin
        issue(OP_CALL, pick_operand());
        issue(OP_RET);
      end
      6: begin
        issue(OP_CALL, rand64());
        issue(OP_ENT, 64'($urandom_range(0, 4)));
        issue(OP_LEA, pick_operand());
        issue(OP_LEV);
      end
      7: begin
        r = rand64();
        issue(OP_ADJ, r);
        issue(OP_ADJ, -r);
      end
      8: begin
        issue(OP_IMM, $urandom_range(0, 1) ? 64'd0 : pick_operand());
        k = $urandom_range(0, 2);
        issue((k == 0) ? OP_JMP : (k == 1) ? OP_JZ : OP_JNZ, pick_operand());
      end
      default: issue(OP_LEA, pick_operand());
    endcase
  endtask

  // edge cases first: overflow corners, shift limits, sign extension, frames
  task automatic directed_start();
    issue(OP_IMM, 64'h7fff_ffff_ffff_ffff);
    issue(OP_PUSH);
    issue(OP_IMM, 64'h8000_0000_0000_0000);
    issue(OP_ADD);
    issue(OP_PUSH);
    issue(OP_IMM, '1);
    issue(OP_DIV);                       // -1 / -1
    issue(OP_PUSH);
    issue(OP_IMM, '1);
    issue(OP_MOD);
    issue(OP_IMM, 64'hffff_ffff_ffff_fffb);
    issue(OP_PUSH);
    issue(OP_IMM, 64'd63);
    issue(OP_SHR);
    store_word(64'h7ff8, 64'h0123_4567_89ab_cdef);  // last data word
    issue(OP_IMM, 64'h7fff);
    issue(OP_LOADC);                     // top byte, sign extended
    issue(OP_IMM, 64'd0);
    issue(OP_JZ, 64'hffff);              // taken, to the last program word
    issue(OP_JNZ, 64'd5);
    issue(OP_CALL, 64'h10);
    issue(OP_ENT, 64'd2);
    issue(OP_LEA, '1);
    issue(OP_LEV);
  endtask

  // one halting instruction ends the stream; the block then repeats itself
  task automatic finale();
    case ($urandom_range(0, 4))
      0: begin
        issue(OP_IMM, pick_operand());
        issue(OP_PUSH);
        issue(OP_EXIT, pick_operand(), 1'b1);
      end
      1: begin
        issue(OP_IMM, pick_operand());
        issue(OP_PUSH);
        issue(OP_IMM, 64'd0);
        issue($urandom_range(0, 1) ? OP_DIV : OP_MOD, 64'd0, 1'b1);
      end
      2: begin
        issue(OP_IMM, 64'(DATA_WORDS_DEF * 8));   // first address past the end
        issue(OP_LOADI, 64'd0, 1'b1);
      end
      3: issue(6'($urandom_range(39, 63)), rand64(), 1'b1);
      default: issue(6'($urandom_range(OP_HOST_LO, OP_HOST_HI)), rand64(), 1'b1);
    endcase
    repeat (3) issue(6'($urandom_range(0, 63)), rand64(), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, one long hold to fill the block
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    vm_result_t got;
    wait (rst_n === 1'b1);
    forever begin
      if (words_seen % 32 == 0) calm_out = ($urandom_range(0, 3) == 0);
      stall = (words_seen == 60) ? 300 : draw_gap(calm_out);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.pc  = out_tdata[15:0];
      got.acc = out_tdata[79:16];
      got.st  = out_tdata[82:80];
      got.xv  = out_tdata[146:83];
      sb.check(got);
      words_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] tops [4];
    logic [15:0] entries [4];
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_STACK_TOP;
    cfg_wdata  = '0;
    items_sent = 0;
    words_seen = 0;
    calm_in    = 0;
    calm_out   = 0;
    vm_pc = ENTRY_RST; vm_sp = STACK_TOP_RST; vm_bp = STACK_TOP_RST;
    vm_acc = '0; vm_halted = 0; halt_st = STS_OK; halt_xv = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // settings per phase: defaults, random, empty stack space, pc near wrap
    tops[0] = 16'd32768;                       entries[0] = 16'd0;
    tops[1] = 16'($urandom_range(64, 4096) * 8); entries[1] = 16'hffff;
    tops[2] = 16'd0;                           entries[2] = 16'($urandom);
    tops[3] = 16'd32768;                       entries[3] = 16'hfffe;

    for (int p = 0; p < 4; p++) begin
      program_regs(tops[p], entries[p]);
      if (p == 0) directed_start();
      while (items_sent < (p + 1) * 112) begin
        random_recipe();
        // once, let the result side catch up completely mid-phase
        if (p == 1 && items_sent >= 170 && items_sent < 175) begin
          idle_input();
          wait_drained();
        end
      end
    end
    finale();

    idle_input();
    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("stack_vm_instruction_executor regression: pass");
    end else begin
      $display("stack_vm_instruction_executor regression: fail");
    end
    $finish;
  end

endmodule
